// ----- design/rsc_pkg.sv -----
`timescale 1ns / 1ps

package rsc_pkg;

  localparam logic [2:0] KIND_PUSH = 3'd0;
  localparam logic [2:0] KIND_PEEK = 3'd1;
  localparam logic [2:0] KIND_ADD  = 3'd2;
  localparam logic [2:0] KIND_SUB  = 3'd3;
  localparam logic [2:0] KIND_MUL  = 3'd4;
  localparam logic [2:0] KIND_DIV  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_ONE   = 3'd3;
  localparam logic [2:0] ST_DIV0  = 3'd4;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam int DVD_W     = 48;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = DVD_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic       accept;
    logic       load_opnd;
    logic       mul_fin;
    logic       div_step;
    logic       div_fin;
    logic       commit;
    logic [2:0] status;
  } rsc_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic top_zero;
    logic div_last;
  } rsc_sts_t;

endpackage

// ----- design/rsc_ram.sv -----
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rsc_ctrl.sv -----
`timescale 1ns / 1ps

module rsc_ctrl
  import rsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output rsc_cmd_t   cmd,
  input  rsc_sts_t   sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPND,
    S_MUL,
    S_DIV,
    S_DIVFIN,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [2:0] st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;
  logic       out_free;

  assign acc      = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.status    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          kind_nxt   = in_kind;
          state_nxt  = S_FIN;
          st_nxt     = ST_OK;
          unique case (in_kind)
            KIND_PUSH: begin
              if (sts.cnt_full) begin
                st_nxt = ST_FULL;
              end
            end
            KIND_PEEK: begin
              if (sts.cnt_zero) begin
                st_nxt = ST_EMPTY;
              end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
              priority if (sts.cnt_zero) begin
                st_nxt = ST_EMPTY;
              end else if (sts.cnt_one) begin
                st_nxt = ST_ONE;
              end else if (in_kind == KIND_DIV && sts.top_zero) begin
                st_nxt = ST_DIV0;
              end else begin
                state_nxt = S_OPND;
              end
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_OPND: begin
        cmd.load_opnd = 1'b1;
        priority if (kind_r == KIND_MUL) begin
          state_nxt = S_MUL;
        end else if (kind_r == KIND_DIV) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DIVFIN;
        end
      end
      S_DIVFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_PUSH;
      st_r        <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      st_r        <= st_nxt;
    end
  end

endmodule

// ----- design/rsc_dp.sv -----
`timescale 1ns / 1ps

module rsc_dp
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_push_value,
  input  rsc_cmd_t           cmd,
  output rsc_sts_t           sts,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic [4:0]         out_depth_now
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [CW-1:0]    count_r, count_nxt;
  logic [31:0]      top_r, top_nxt;
  logic [2:0]       kind_r;
  logic [31:0]      push_r;
  logic [31:0]      sec;
  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic             ram_we;

  logic [31:0]        res_r;
  logic signed [63:0] prod_r;

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       dvs_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [32:0] sum;
  logic [32:0] dif;
  logic [31:0] s_abs, t_abs;
  logic [31:0] mul_sat;
  logic [31:0] div_sat;
  logic [31:0] dep_ext;

  logic [2:0]  ost_r;
  logic [31:0] otop_r;
  logic [4:0]  odep_r;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  rsc_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (top_r),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (sec)
  );

  assign sts.cnt_zero = (count_r == '0);
  assign sts.cnt_one  = (count_r == CW'(1));
  assign sts.cnt_full = (count_r == CW'(STACK_DEPTH));
  assign sts.top_zero = (top_r == '0);
  assign sts.div_last = (dcnt_r == DCNT_W'(DIV_STEPS - 1));

  assign sum   = {sec[31], sec} + {top_r[31], top_r};
  assign dif   = {sec[31], sec} - {top_r[31], top_r};
  assign s_abs = sec[31] ? (32'd0 - sec) : sec;
  assign t_abs = top_r[31] ? (32'd0 - top_r) : top_r;

  always_comb begin
    priority if (!prod_r[63] && (|prod_r[62:47])) begin
      mul_sat = Q_MAX;
    end else if (prod_r[63] && !(&prod_r[62:47])) begin
      mul_sat = Q_MIN;
    end else begin
      mul_sat = prod_r[47:16];
    end
  end

  always_comb begin
    if (!neg_r) begin
      div_sat = (dvd_r > DVD_W'(Q_MAX)) ? Q_MAX : dvd_r[31:0];
    end else begin
      div_sat = (dvd_r > DVD_W'(Q_MIN)) ? Q_MIN : (32'd0 - dvd_r[31:0]);
    end
  end

  always_comb begin
    logic [32:0] rsh;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      rsh = {rem_nxt, dvd_nxt[DVD_W-1]};
      if (rsh >= {1'b0, dvs_r}) begin
        rsh     = rsh - {1'b0, dvs_r};
        dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b1};
      end else begin
        dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
      end
      rem_nxt = rsh[31:0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    ram_we    = 1'b0;
    if (cmd.commit && cmd.status == ST_OK) begin
      if (kind_r == KIND_PUSH) begin
        ram_we    = (count_r != '0);
        top_nxt   = push_r;
        count_nxt = count_r + CW'(1);
      end else if (kind_r == KIND_ADD || kind_r == KIND_SUB ||
                   kind_r == KIND_MUL || kind_r == KIND_DIV) begin
        top_nxt   = res_r;
        count_nxt = cnt_m1;
      end
    end
  end

  assign dep_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.accept) begin
      kind_r <= in_kind;
      push_r <= in_push_value;
    end
    if (cmd.load_opnd) begin
      prod_r <= $signed(sec) * $signed(top_r);
      dvd_r  <= {s_abs, 16'd0};
      dvs_r  <= t_abs;
      rem_r  <= '0;
      neg_r  <= sec[31] ^ top_r[31];
      dcnt_r <= '0;
      if (kind_r == KIND_ADD) begin
        res_r <= (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
      end else begin
        res_r <= (dif[32] != dif[31]) ? (dif[32] ? Q_MIN : Q_MAX) : dif[31:0];
      end
    end
    if (cmd.mul_fin) begin
      res_r <= mul_sat;
    end
    if (cmd.div_step) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.div_fin) begin
      res_r <= div_sat;
    end
    if (cmd.commit) begin
      ost_r  <= cmd.status;
      otop_r <= (count_nxt == '0) ? 32'd0 : top_nxt;
      odep_r <= dep_ext[4:0];
    end
  end

  assign out_status    = ost_r;
  assign out_top_value = otop_r;
  assign out_depth_now = odep_r;

endmodule

// ----- design/rpn_stack_calculator.sv -----
`timescale 1ns / 1ps

// Reverse Polish calculator on a stack of signed Q16.16 values, STACK_DEPTH entries deep.
// Each request carries a command (push, peek, add, subtract, multiply, divide) and
// returns exactly one response with a status code, the new top of stack and the new
// depth. The top entry lives in a register and the rest in a RAM with one write port and
// one registered read port, from which an arithmetic command reads its second operand.
// Push, peek, unused codes and every error case go straight to the response; add and
// subtract first load the operands, multiply then adds a product step, and divide runs a
// restoring divider that resolves 2 quotient bits per cycle over a 48-bit dividend.
// A new request is accepted on the cycle after the previous one has been committed to
// the output register, even while that response is still stalled.

module rpn_stack_calculator
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic [4:0]         out_depth_now
);

  rsc_cmd_t cmd;
  rsc_sts_t sts;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rsc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth_now (out_depth_now)
  );

endmodule
